/* rtl/core/nac_pkg.sv */
// Shared codes and types for the nibble address accumulator CPU.
`default_nettype none

package nac_pkg;

    localparam int unsigned PC_W     = 4;
    localparam int unsigned WORD_W   = 8;
    localparam int unsigned DEPTH    = 16;
    localparam int unsigned HALT_DEF = 15;

    // Item operations
    localparam logic [1:0] OPN_EXEC      = 2'd0;
    localparam logic [1:0] OPN_LOAD_CODE = 2'd1;
    localparam logic [1:0] OPN_LOAD_DATA = 2'd2;

    // Instruction opcodes (high nibble)
    localparam logic [3:0] OP_READ      = 4'd0;
    localparam logic [3:0] OP_WRITE     = 4'd1;
    localparam logic [3:0] OP_ADD       = 4'd2;
    localparam logic [3:0] OP_SUB       = 4'd3;
    localparam logic [3:0] OP_JUMP      = 4'd4;
    localparam logic [3:0] OP_JMP_FF    = 4'd5;
    localparam logic [3:0] OP_JMP_Z     = 4'd6;
    localparam logic [3:0] OP_LOGIC     = 4'd7;
    localparam logic [3:0] OP_READ_IND  = 4'd8;
    localparam logic [3:0] OP_WRITE_IND = 4'd9;
    localparam logic [3:0] OP_INCDEC    = 4'd10;
    localparam logic [3:0] OP_PRINT     = 4'd11;
    localparam logic [3:0] OP_JMP_NFF   = 4'd13;
    localparam logic [3:0] OP_JMP_NZ    = 4'd14;

    // Logic group selectors (operand nibble of OP_LOGIC)
    localparam logic [3:0] LG_SHL      = 4'd0;
    localparam logic [3:0] LG_SHR      = 4'd1;
    localparam logic [3:0] LG_AND      = 4'd2;
    localparam logic [3:0] LG_OR       = 4'd3;
    localparam logic [3:0] LG_NOT      = 4'd4;
    localparam logic [3:0] LG_JMP_ACC  = 4'd5;
    localparam logic [3:0] LG_READ_ACC = 4'd6;
    localparam logic [3:0] LG_NOP      = 4'd7;

    localparam logic [3:0] PRINT_ADDR = 4'd15;

    // Outcome of one item, handed from the execute logic to the state registers
    typedef struct packed {
        logic [PC_W-1:0]   pc;
        logic [WORD_W-1:0] acc;
        logic              code_we;
        logic              data_we;
        logic [PC_W-1:0]   wr_addr;
        logic [WORD_W-1:0] wr_data;
        logic              printed;
    } t_exec_res;

endpackage

`default_nettype wire

/* rtl/core/nac_stores.sv */
// Code and data stores: 16-byte register files with one write port each.
`default_nettype none

module nac_stores
    import nac_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_commit,
    input  wire t_exec_res         i_res,
    input  wire logic [PC_W-1:0]   i_code_addr,
    input  wire logic [PC_W-1:0]   i_ra_addr,
    input  wire logic [PC_W-1:0]   i_rp_addr,
    output logic      [WORD_W-1:0] o_inst,
    output logic      [WORD_W-1:0] o_ra_data,
    output logic      [WORD_W-1:0] o_rp_data,
    output logic      [WORD_W-1:0] o_d0_data
);

    logic [WORD_W-1:0] r_code [DEPTH];
    logic [WORD_W-1:0] r_data [DEPTH];

    // Write the stores when a beat commits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < DEPTH; i++) begin
                r_code[i] <= '0;
                r_data[i] <= '0;
            end
        end else if (i_commit) begin
            if (i_res.code_we) begin
                r_code[i_res.wr_addr] <= i_res.wr_data;
            end
            if (i_res.data_we) begin
                r_data[i_res.wr_addr] <= i_res.wr_data;
            end
        end
    end

    // Read ports: fetch, direct operand, pointer target, fixed address zero
    assign o_inst    = r_code[i_code_addr];
    assign o_ra_data = r_data[i_ra_addr];
    assign o_rp_data = r_data[i_rp_addr];
    assign o_d0_data = r_data[0];

endmodule

`default_nettype wire

/* rtl/core/nac_exec.sv */
// Single-pass execute logic: decodes one beat and works out the next state.
`default_nettype none

module nac_exec
    import nac_pkg::*;
#(
    parameter int unsigned HALT_ADDRESS = HALT_DEF
) (
    input  wire logic [1:0]        i_operation,
    input  wire logic [PC_W-1:0]   i_address,
    input  wire logic [WORD_W-1:0] i_load_value,
    input  wire logic [PC_W-1:0]   i_pc,
    input  wire logic [WORD_W-1:0] i_acc,
    input  wire logic [WORD_W-1:0] i_inst,
    input  wire logic [WORD_W-1:0] i_ra_data,
    input  wire logic [WORD_W-1:0] i_rp_data,
    input  wire logic [WORD_W-1:0] i_d0_data,
    output logic      [PC_W-1:0]   o_ra_addr,
    output logic      [PC_W-1:0]   o_rp_addr,
    output t_exec_res              o_res
);

    localparam logic [PC_W-1:0] L_HALT = PC_W'(HALT_ADDRESS);

    logic [3:0]        op;
    logic [3:0]        arg;
    logic [PC_W-1:0]   pc_inc;
    logic [WORD_W-1:0] incdec;
    logic              run;
    t_exec_res         ex;

    assign op     = i_inst[7:4];
    assign arg    = i_inst[3:0];
    assign pc_inc = i_pc + PC_W'(1);
    assign run    = (i_operation == OPN_EXEC) && (i_pc < L_HALT);

    // Select operand addresses: low three bits for the logic XOR and inc/dec forms
    assign o_ra_addr = ((op == OP_LOGIC) || (op == OP_INCDEC)) ? {1'b0, arg[2:0]} : arg;
    assign o_rp_addr = (op == OP_LOGIC) ? i_acc[3:0] : i_ra_data[3:0];

    assign incdec = arg[3] ? (i_ra_data - WORD_W'(1)) : (i_ra_data + WORD_W'(1));

    // Decode the instruction
    always_comb begin
        ex         = '0;
        ex.pc      = pc_inc;
        ex.acc     = i_acc;
        ex.wr_addr = arg;
        ex.wr_data = i_acc;
        case (op)
            OP_WRITE: begin
                ex.data_we = 1'b1;
            end
            OP_ADD:  ex.acc = i_acc + i_ra_data;
            OP_SUB:  ex.acc = i_acc - i_ra_data;
            OP_JUMP: ex.pc  = arg;
            OP_JMP_FF:  ex.pc = (i_acc == 8'hFF) ? arg : pc_inc;
            OP_JMP_Z:   ex.pc = (i_acc == 8'h00) ? arg : pc_inc;
            OP_JMP_NFF: ex.pc = (i_acc != 8'hFF) ? arg : pc_inc;
            OP_JMP_NZ:  ex.pc = (i_acc != 8'h00) ? arg : pc_inc;
            OP_READ_IND: ex.acc = i_rp_data;
            OP_WRITE_IND: begin
                ex.data_we = 1'b1;
                ex.wr_addr = i_ra_data[3:0];
            end
            OP_INCDEC: begin
                ex.data_we = 1'b1;
                ex.wr_addr = {1'b0, arg[2:0]};
                ex.wr_data = incdec;
                ex.acc     = incdec;
            end
            OP_PRINT: begin
                ex.data_we = 1'b1;
                ex.wr_addr = PRINT_ADDR;
                ex.wr_data = i_ra_data;
            end
            OP_LOGIC: begin
                case (arg)
                    LG_SHL:      ex.acc = {i_acc[6:0], 1'b0};
                    LG_SHR:      ex.acc = {1'b0, i_acc[7:1]};
                    LG_AND:      ex.acc = i_acc & i_d0_data;
                    LG_OR:       ex.acc = i_acc | i_d0_data;
                    LG_NOT:      ex.acc = ~i_acc;
                    LG_JMP_ACC:  ex.pc  = i_acc[3:0];
                    LG_READ_ACC: ex.acc = i_rp_data;
                    LG_NOP:      ex.pc  = i_pc;
                    default:     ex.acc = i_acc ^ i_ra_data;
                endcase
            end
            default: ex.acc = i_ra_data;
        endcase
        ex.printed = ex.data_we && (ex.wr_addr == PRINT_ADDR);
    end

    // Loads and idle beats leave pc and acc alone and never print
    always_comb begin
        o_res = '0;
        if (run) begin
            o_res = ex;
        end else begin
            o_res.pc      = i_pc;
            o_res.acc     = i_acc;
            o_res.wr_addr = i_address;
            o_res.wr_data = i_load_value;
            o_res.code_we = (i_operation == OPN_LOAD_CODE);
            o_res.data_we = (i_operation == OPN_LOAD_DATA);
        end
    end

endmodule

`default_nettype wire

/* rtl/core/nibble_address_accumulator_cpu.sv */
// Top level of the nibble address accumulator CPU.
//
// Input channel: i_in_valid / o_in_stall carries one beat of operation, address and
// load_value. Operation 0 executes the instruction at the program counter, 1 loads
// a code byte, 2 loads a data byte, 3 is ignored.
// Output channel: o_out_valid / i_out_stall carries one result beat per input beat:
// program counter, accumulator, halted flag and any print to data address 15.
// A beat is taken into an input register, executed in one pass of logic against
// the code and data register files, and lands in the output register; the state
// is updated on that same edge. Throughput is one beat per cycle while the
// receiver does not stall, set by the single fetch-execute pass.
// When the receiver stalls, the output register holds its beat and the input
// register can still take one more; only with both full is o_in_stall raised.
// Synchronous reset clears pc, accumulator, both stores and both valid flags;
// no pass over the stores is needed afterwards.
`default_nettype none

module nibble_address_accumulator_cpu
    import nac_pkg::*;
#(
    parameter int unsigned HALT_ADDRESS = HALT_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_stall,
    input  wire logic [1:0]        i_operation,
    input  wire logic [3:0]        i_address,
    input  wire logic [7:0]        i_load_value,
    output logic                   o_out_valid,
    input  wire logic              i_out_stall,
    output logic      [3:0]        o_program_counter,
    output logic      [7:0]        o_accumulator,
    output logic                   o_halted,
    output logic                   o_printed,
    output logic      [7:0]        o_printed_value
);

    localparam logic [PC_W-1:0] L_HALT = PC_W'(HALT_ADDRESS);

    logic              r_in_valid;
    logic [1:0]        r_operation;
    logic [PC_W-1:0]   r_address;
    logic [WORD_W-1:0] r_load_value;
    logic [PC_W-1:0]   r_pc;
    logic [WORD_W-1:0] r_acc;
    logic              r_out_valid;
    logic [PC_W-1:0]   r_out_pc;
    logic [WORD_W-1:0] r_out_acc;
    logic              r_out_halted;
    logic              r_out_printed;
    logic [WORD_W-1:0] r_out_pval;

    logic              out_free;
    logic              commit;
    logic              in_take;
    logic [WORD_W-1:0] inst;
    logic [WORD_W-1:0] ra_data;
    logic [WORD_W-1:0] rp_data;
    logic [WORD_W-1:0] d0_data;
    logic [PC_W-1:0]   ra_addr;
    logic [PC_W-1:0]   rp_addr;
    t_exec_res         res;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign commit     = r_in_valid && out_free;
    assign o_in_stall = r_in_valid && !out_free;
    assign in_take    = i_in_valid && !o_in_stall;

    nac_stores u_stores (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_commit    (commit),
        .i_res       (res),
        .i_code_addr (r_pc),
        .i_ra_addr   (ra_addr),
        .i_rp_addr   (rp_addr),
        .o_inst      (inst),
        .o_ra_data   (ra_data),
        .o_rp_data   (rp_data),
        .o_d0_data   (d0_data)
    );

    nac_exec #(
        .HALT_ADDRESS (HALT_ADDRESS)
    ) u_exec (
        .i_operation  (r_operation),
        .i_address    (r_address),
        .i_load_value (r_load_value),
        .i_pc         (r_pc),
        .i_acc        (r_acc),
        .i_inst       (inst),
        .i_ra_data    (ra_data),
        .i_rp_data    (rp_data),
        .i_d0_data    (d0_data),
        .o_ra_addr    (ra_addr),
        .o_rp_addr    (rp_addr),
        .o_res        (res)
    );

    // Input register: take a beat whenever the slot is free or draining
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take || commit) begin
            r_in_valid <= in_take;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_operation  <= i_operation;
            r_address    <= i_address;
            r_load_value <= i_load_value;
        end
    end

    // Architectural registers: advance on commit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc  <= '0;
            r_acc <= '0;
        end else if (commit) begin
            r_pc  <= res.pc;
            r_acc <= res.acc;
        end
    end

    // Output register: hold while stalled
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (commit) begin
            r_out_pc      <= res.pc;
            r_out_acc     <= res.acc;
            r_out_halted  <= (res.pc >= L_HALT);
            r_out_printed <= res.printed;
            r_out_pval    <= res.printed ? res.wr_data : '0;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_program_counter = r_out_pc;
    assign o_accumulator     = r_out_acc;
    assign o_halted          = r_out_halted;
    assign o_printed         = r_out_printed;
    assign o_printed_value   = r_out_pval;

    // Halted flag agrees with the reported program counter
    a_halt_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_halted == (o_program_counter >= L_HALT)))
        else $error("halted flag disagrees with program counter");

    // No print value without a print
    a_print_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_printed) |-> (o_printed_value == '0))
        else $error("print value set without a print");

    // Input stalls only when the output register is full and blocked
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (o_out_valid && i_out_stall && r_in_valid))
        else $error("input stalled with room downstream");

    // A committed beat appears at the output on the next edge
    a_commit_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        commit |=> o_out_valid)
        else $error("committed beat lost");

endmodule

`default_nettype wire
